// ===== sv/bmpd_pkg.sv =====
// shared types, constants and helpers for the bmp pixel decoder
// used by bmpd_ctrl, bmpd_datapath and bmp_preview_pixel_decoder
package bmpd_pkg;
   localparam int unsigned MAX_DIMENSION  = 512;
   localparam int unsigned MAX_FILE_BYTES = 1048576;
   localparam int unsigned POS_W = 21;

   localparam logic [1:0] KIND_ACCEPT = 2'd0;
   localparam logic [1:0] KIND_PIXEL  = 2'd1;
   localparam logic [1:0] KIND_REJECT = 2'd2;

   localparam logic CSR_FILE_LENGTH = 1'b0;
   localparam logic CSR_MAX_DECODED = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE, ST_HEADER, ST_PIXELS, ST_DONE
   } stage_type;

   // controller to datapath
   typedef struct packed {
      logic restart;     // clear counters
      logic hdr_step;    // header byte taken
      logic pix_step;    // pixel stage byte taken
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic len_bad;     // file length bad at byte zero
      logic at_main;     // header position 53
      logic at_masks;    // header position 65
      logic main_ok;
      logic main_bf;     // bitfields still to come
      logic masks_ok;
      logic last_row;    // this byte finishes the image
   } status_type;

   // c*255/31 for five bits, reciprocal of 31 scaled by 2^18
   function automatic logic [7:0] expand5(input logic [4:0] c);
      logic [12:0] x;
      logic [26:0] p;
      x = {c, 8'd0} - {8'd0, c};
      p = {14'd0, x} * 27'd8457;
      return p[25:18];
   endfunction

   // c*255/63 for six bits, equal to 4c + c/21
   function automatic logic [7:0] expand6(input logic [5:0] c);
      logic [11:0] q;
      q = {6'd0, c} * 12'd49;
      return {c, 2'd0} + {6'd0, q[11:10]};
   endfunction
endpackage

// ===== sv/bmp_preview_pixel_decoder.sv =====
// top level of the bmp pixel decoder: handshakes, csr and output register
// depends on bmpd_pkg, bmpd_ctrl, bmpd_datapath
//
//  channel | direction | handshake     | payload
//  req     | in        | valid / stall | data_byte, start_req
//  rsp     | out       | valid / stall | kind, pixel_index, color, size
//  csr     | in        | valid / ready | index, data
//
// one byte per cycle; a result sits in the output register the cycle after
// its request. the size products are formed at header bytes 30 and 31, ahead
// of the header check on byte 53. reset clears the parse stage and the result
// valid and sets the csr registers to their defaults. req stalls only while a
// result waits in the output register and rsp is stalled.
module bmp_preview_pixel_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_start_req,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [17:0] rsp_pixel_index,
   output logic [7:0]  rsp_blue,
   output logic [7:0]  rsp_green,
   output logic [7:0]  rsp_red,
   output logic [7:0]  rsp_alpha,
   output logic [9:0]  rsp_image_width,
   output logic [9:0]  rsp_image_height,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [20:0] csr_data
);
   logic [20:0] flen_ff, maxd_ff;
   logic        take, emit, pix_valid, fire;
   logic [1:0]  emit_kind;
   bmpd_pkg::cmd_type    cmd;
   bmpd_pkg::status_type sts;
   logic [17:0] pidx;
   logic [7:0]  pb, pg, pr;
   logic [9:0]  iw, ih;

   assign csr_ready = 1'b1;
   assign req_stall = rsp_valid && rsp_stall;
   assign take = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         flen_ff <= '0;
         maxd_ff <= 21'(bmpd_pkg::MAX_FILE_BYTES);
      end else if (csr_valid) begin
         if (csr_index == bmpd_pkg::CSR_FILE_LENGTH) flen_ff <= csr_data;
         else maxd_ff <= csr_data;
      end
   end

   bmpd_ctrl u_ctrl (
      .clock(clock), .reset(reset), .take(take), .start(req_start_req),
      .sts(sts), .cmd(cmd), .emit(emit), .emit_kind(emit_kind)
   );

   bmpd_datapath u_dp (
      .clock(clock), .data_byte(req_data_byte), .file_length(flen_ff),
      .max_decoded(maxd_ff), .cmd(cmd), .sts(sts), .pix_valid(pix_valid),
      .pix_index(pidx), .pix_b(pb), .pix_g(pg), .pix_r(pr),
      .img_w(iw), .img_h(ih)
   );

   assign fire = emit || pix_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (!req_stall) begin
         rsp_valid <= fire;
      end
      if (!req_stall && fire) begin
         rsp_kind <= emit_kind;
         if (emit_kind == bmpd_pkg::KIND_PIXEL) begin
            rsp_pixel_index <= pidx;
            rsp_blue <= pb; rsp_green <= pg; rsp_red <= pr; rsp_alpha <= 8'hff;
            rsp_image_width <= iw; rsp_image_height <= ih;
         end else begin
            rsp_pixel_index <= '0;
            rsp_blue <= '0; rsp_green <= '0; rsp_red <= '0; rsp_alpha <= '0;
            if (emit_kind == bmpd_pkg::KIND_ACCEPT) begin
               rsp_image_width <= iw;
               rsp_image_height <= ih;
            end else begin
               rsp_image_width <= '0; rsp_image_height <= '0;
            end
         end
      end
   end
endmodule

// ===== sv/bmpd_ctrl.sv =====
// parse stage state machine of the bmp pixel decoder
// depends on bmpd_pkg
module bmpd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 take,
   input  logic                 start,
   input  bmpd_pkg::status_type sts,
   output bmpd_pkg::cmd_type    cmd,
   output logic                 emit,
   output logic [1:0]           emit_kind
);
   bmpd_pkg::stage_type state_ff, state_in;
   bmpd_pkg::stage_type cur;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bmpd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cur = start ? bmpd_pkg::ST_HEADER : state_ff;
   end

   always_comb begin
      state_in = state_ff;
      if (take) begin
         unique case (cur)
            bmpd_pkg::ST_HEADER: begin
               if (sts.len_bad) begin
                  state_in = bmpd_pkg::ST_DONE;
               end else if (sts.at_main) begin
                  if (!sts.main_ok) state_in = bmpd_pkg::ST_DONE;
                  else if (!sts.main_bf) state_in = bmpd_pkg::ST_PIXELS;
                  else state_in = bmpd_pkg::ST_HEADER;
               end else if (sts.at_masks) begin
                  state_in = sts.masks_ok ? bmpd_pkg::ST_PIXELS : bmpd_pkg::ST_DONE;
               end else begin
                  state_in = bmpd_pkg::ST_HEADER;
               end
            end
            bmpd_pkg::ST_PIXELS: begin
               if (sts.last_row) state_in = bmpd_pkg::ST_DONE;
            end
            default: state_in = state_ff;
         endcase
      end
   end

   always_comb begin
      cmd = '0;
      emit = 1'b0;
      emit_kind = bmpd_pkg::KIND_REJECT;
      if (take) begin
         cmd.restart = start;
         unique case (cur)
            bmpd_pkg::ST_HEADER: begin
               cmd.hdr_step = 1'b1;
               if (sts.len_bad) begin
                  emit = 1'b1;
               end else if (sts.at_main) begin
                  if (!sts.main_ok) emit = 1'b1;
                  else if (!sts.main_bf) begin
                     emit = 1'b1;
                     emit_kind = bmpd_pkg::KIND_ACCEPT;
                  end
               end else if (sts.at_masks) begin
                  emit = 1'b1;
                  if (sts.masks_ok) emit_kind = bmpd_pkg::KIND_ACCEPT;
               end
            end
            bmpd_pkg::ST_PIXELS: begin
               cmd.pix_step = 1'b1;
               emit_kind = bmpd_pkg::KIND_PIXEL;
            end
            default: emit = 1'b0;
         endcase
      end
   end
endmodule

// ===== sv/bmpd_datapath.sv =====
// header capture, checks, pixel assembly and channel expansion
// depends on bmpd_pkg; driven by bmpd_ctrl
module bmpd_datapath (
   input  logic                 clock,
   input  logic [7:0]           data_byte,
   input  logic [20:0]          file_length,
   input  logic [20:0]          max_decoded,
   input  bmpd_pkg::cmd_type    cmd,
   output bmpd_pkg::status_type sts,
   output logic                 pix_valid,
   output logic [17:0]          pix_index,
   output logic [7:0]           pix_b,
   output logic [7:0]           pix_g,
   output logic [7:0]           pix_r,
   output logic [9:0]           img_w,
   output logic [9:0]           img_h
);
   logic [20:0] pos_ff;
   logic [7:0]  hb_ff [0:65];
   logic [9:0]  w_ff, h_ff, row_ff, col_ff;
   logic [11:0] rbc_ff, stride_ff;
   logic [1:0]  k_ff;
   logic [23:0] pix_ff;
   logic [20:0] off_ff;
   logic        td_ff, bpb2_ff, bpb3_ff, is565_ff;
   logic [21:0] area_ff, need_ff;
   logic [20:0] pos;
   logic [11:0] rbc;
   logic [9:0]  row, col;
   logic [1:0]  k;
   logic [23:0] pix;
   logic        last_row_c;

   // restart clears counters for this byte too
   always_comb begin
      pos = cmd.restart ? '0 : pos_ff;
      rbc = cmd.restart ? '0 : rbc_ff;
      row = cmd.restart ? '0 : row_ff;
      col = cmd.restart ? '0 : col_ff;
      k   = cmd.restart ? '0 : k_ff;
      pix = cmd.restart ? '0 : pix_ff;
   end

   // size products from stored header bytes, stride at byte 30, totals at byte 31
   logic [9:0]  w10, h10, hr_lo;
   logic [5:0]  bpp6;
   logic [14:0] wbits, wsum;
   logic [11:0] stride_n;
   logic [19:0] wh;
   logic [21:0] area_n, need_n;
   always_comb begin
      w10 = {hb_ff[19][1:0], hb_ff[18]};
      hr_lo = {hb_ff[23][1:0], hb_ff[22]};
      h10 = hb_ff[25][7] ? (~hr_lo + 10'd1) : hr_lo;
      bpp6 = hb_ff[28][5:0];
      wbits = {5'd0, w10} * {9'd0, bpp6};
      wsum = wbits + 15'd31;
      stride_n = {wsum[14:5], 2'b00};
      wh = {10'd0, w10} * {10'd0, h10};
      area_n = {wh, 2'b00};
      need_n = {10'd0, stride_ff} * {12'd0, h10};
   end

   function automatic logic [31:0] h32(input int a, input logic [7:0] nb [0:65]);
      return {nb[a+3], nb[a+2], nb[a+1], nb[a]};
   endfunction

   logic [7:0]  nb [0:65];
   logic [31:0] w32, hr32, hm32, off32, comp32, min32, eff_off;
   logic [15:0] bpp;
   logic        neg, ok;
   always_comb begin
      for (int i = 0; i < 66; i++) nb[i] = hb_ff[i];
      if (pos < 21'd66) nb[pos[6:0]] = data_byte;
      w32 = h32(18, nb);
      hr32 = h32(22, nb);
      neg = hr32[31];
      hm32 = neg ? (~hr32 + 32'd1) : hr32;
      bpp = {nb[29], nb[28]};
      comp32 = h32(30, nb);
      off32 = h32(10, nb);
      min32 = (comp32 == 32'd3) ? 32'd66 : 32'd54;
      eff_off = (off32 == 32'd0) ? min32 : off32;
      ok = nb[0] == 8'h42 && nb[1] == 8'h4d && h32(14, nb) == 32'd40
         && w32 != 0 && w32 <= 32'(bmpd_pkg::MAX_DIMENSION)
         && hm32 != 0 && hm32 <= 32'(bmpd_pkg::MAX_DIMENSION)
         && nb[26] == 8'd1 && nb[27] == 8'd0
         && area_ff <= {1'b0, max_decoded}
         && (bpp == 16'd16 || bpp == 16'd24 || bpp == 16'd32)
         && (comp32 == 0 || (bpp == 16'd16 && comp32 == 32'd3))
         && eff_off >= min32 && eff_off <= {11'd0, file_length}
         && {10'd0, need_ff} <= ({11'd0, file_length} - eff_off);
      sts.len_bad = pos == 0 && (file_length < 21'd54
         || 32'(file_length) > 32'(bmpd_pkg::MAX_FILE_BYTES));
      sts.at_main = pos == 21'd53;
      sts.at_masks = pos == 21'd65;
      sts.main_ok = ok;
      sts.main_bf = comp32 == 32'd3;
      sts.masks_ok = h32(62, nb) == 32'h1f &&
         ((h32(54, nb) == 32'hf800 && h32(58, nb) == 32'h07e0) ||
          (h32(54, nb) == 32'h7c00 && h32(58, nb) == 32'h03e0));
      sts.last_row = last_row_c;
   end

   logic in_data, last_k, row_end;
   logic [23:0] pix_n;
   always_comb begin
      in_data = pos >= off_ff;
      last_k = bpb2_ff ? (k == 2'd1) : bpb3_ff ? (k == 2'd2) : (k == 2'd3);
      row_end = rbc + 12'd1 >= stride_ff;
      pix_n = pix;
      if (k == 2'd0) pix_n[7:0] = data_byte;
      if (k == 2'd1) pix_n[15:8] = data_byte;
      if (k == 2'd2) pix_n[23:16] = data_byte;
      last_row_c = in_data && row_end && (row + 10'd1 >= h_ff);
      pix_valid = cmd.pix_step && in_data && col < w_ff && last_k;
   end

   logic [9:0]  drow;
   logic [19:0] idx;
   always_comb begin
      drow = td_ff ? row : (h_ff - 10'd1 - row);
      idx = drow * w_ff + {10'd0, col};
      pix_index = idx[17:0];
      if (bpb2_ff) begin
         pix_b = bmpd_pkg::expand5(pix_n[4:0]);
         pix_g = is565_ff ? bmpd_pkg::expand6(pix_n[10:5]) : bmpd_pkg::expand5(pix_n[9:5]);
         pix_r = is565_ff ? bmpd_pkg::expand5(pix_n[15:11]) : bmpd_pkg::expand5(pix_n[14:10]);
      end else begin
         pix_b = pix_n[7:0];
         pix_g = pix_n[15:8];
         pix_r = pix_n[23:16];
      end
      // size of the header being accepted on this very byte
      img_w = sts.at_main ? w32[9:0] : w_ff;
      img_h = sts.at_main ? hm32[9:0] : h_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.restart) begin
         rbc_ff <= '0; row_ff <= '0; col_ff <= '0;
         k_ff <= '0; pix_ff <= '0;
      end
      if (cmd.hdr_step) begin
         pos_ff <= pos + 21'd1;
         if (pos < 21'd66) hb_ff[pos[6:0]] <= data_byte;
         if (pos == 21'd30) stride_ff <= stride_n;
         if (pos == 21'd31) begin
            area_ff <= area_n; need_ff <= need_n;
         end
         if (sts.at_main) begin
            w_ff <= w32[9:0]; h_ff <= hm32[9:0];
            off_ff <= eff_off[20:0];
            td_ff <= neg; bpb2_ff <= bpp == 16'd16; bpb3_ff <= bpp == 16'd24;
         end
         if (sts.at_masks) is565_ff <= h32(54, nb) == 32'hf800;
         if (sts.at_main && !sts.main_bf) is565_ff <= 1'b0;
      end
      if (cmd.pix_step) begin
         pos_ff <= pos + 21'd1;
         if (in_data) begin
            if (row_end) begin
               rbc_ff <= '0; row_ff <= row + 10'd1; col_ff <= '0; k_ff <= '0;
               pix_ff <= '0;
            end else begin
               rbc_ff <= rbc + 12'd1;
               if (last_k) begin
                  k_ff <= '0; col_ff <= col + 10'd1; pix_ff <= '0;
               end else begin
                  k_ff <= k + 2'd1;
                  pix_ff <= pix_n;
               end
            end
         end
      end
   end
endmodule

// ===== test/bmpd_checker.sv =====
// scoreboard for the bmp pixel decoder: watches the csr, request and result
// channels, predicts each result and compares it; depends on bmpd_pkg
module bmpd_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_start_req,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_kind,
   input  logic [17:0] rsp_pixel_index,
   input  logic [7:0]  rsp_blue,
   input  logic [7:0]  rsp_green,
   input  logic [7:0]  rsp_red,
   input  logic [7:0]  rsp_alpha,
   input  logic [9:0]  rsp_image_width,
   input  logic [9:0]  rsp_image_height,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [20:0] csr_data,
   output int          fail_count,
   output int          pending,
   output int          checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [1:0]  kind;
      logic [17:0] index;
      logic [7:0]  blue;
      logic [7:0]  green;
      logic [7:0]  red;
      logic [7:0]  alpha;
      logic [9:0]  width;
      logic [9:0]  height;
   } result_type;

   result_type expected_results[$];

   logic [20:0] file_len;
   logic [20:0] max_dec;
   bmpd_pkg::stage_type stage;
   int unsigned pos, rows, row_bytes, pix_acc;
   logic [7:0]  hdr [66];
   int unsigned img_w, img_h, img_off, stride, bpb;
   bit          top_down, is565;

   function automatic int unsigned hdr16(int at);
      return {hdr[at + 1], hdr[at]};
   endfunction

   function automatic int unsigned hdr32(int at);
      return {hdr[at + 3], hdr[at + 2], hdr[at + 1], hdr[at]};
   endfunction

   // 0 fail, 1 accepted, 2 masks still to come
   function automatic int header_verdict();
      int unsigned w, hraw, h, bpp, comp, off, minimum;
      bit neg;
      w = hdr32(18);
      hraw = hdr32(22);
      bpp = hdr16(28);
      comp = hdr32(30);
      off = hdr32(10);
      neg = hraw[31];
      h = neg ? (~hraw + 1) : hraw;
      if (hdr[0] != 8'h42 || hdr[1] != 8'h4d) return 0;
      if (hdr32(14) != 40 || w == 0 || w > bmpd_pkg::MAX_DIMENSION) return 0;
      if (h == 0 || h > bmpd_pkg::MAX_DIMENSION || hdr16(26) != 1) return 0;
      if (w * h * 4 > max_dec) return 0;
      if (bpp != 16 && bpp != 24 && bpp != 32) return 0;
      if (comp != 0 && !(bpp == 16 && comp == 3)) return 0;
      minimum = (comp == 3) ? 66 : 54;
      if (off == 0) off = minimum;
      if (off < minimum || off > file_len) return 0;
      stride = ((w * bpp + 31) / 32) * 4;
      if (stride * h > file_len - off) return 0;
      img_w = w;
      img_h = h;
      img_off = off;
      bpb = bpp / 8;
      top_down = neg;
      is565 = 0;
      return (comp == 3) ? 2 : 1;
   endfunction

   function automatic bit masks_ok();
      int unsigned r, g, b;
      r = hdr32(54);
      g = hdr32(58);
      b = hdr32(62);
      if (b != 32'h1f) return 0;
      if (r == 32'hf800 && g == 32'h07e0) begin
         is565 = 1;
         return 1;
      end
      if (r == 32'h7c00 && g == 32'h03e0) begin
         is565 = 0;
         return 1;
      end
      return 0;
   endfunction

   task automatic push_verdict(input bit ok);
      result_type r;
      r = '0;
      if (ok) begin
         r.kind = bmpd_pkg::KIND_ACCEPT;
         r.width = img_w[9:0];
         r.height = img_h[9:0];
         stage = bmpd_pkg::ST_PIXELS;
         pos++;
      end else begin
         r.kind = bmpd_pkg::KIND_REJECT;
         stage = bmpd_pkg::ST_DONE;
      end
      expected_results.push_back(r);
   endtask

   task automatic push_pixel(input int unsigned col);
      result_type r;
      int unsigned row, p;
      row = top_down ? rows : img_h - 1 - rows;
      p = pix_acc;
      r.kind = bmpd_pkg::KIND_PIXEL;
      r.index = 18'(row * img_w + col);
      if (bpb == 2) begin
         p = p & 32'hffff;
         r.blue = 8'((p & 32'h1f) * 255 / 31);
         if (is565) begin
            r.green = 8'(((p & 32'h07e0) >> 5) * 255 / 63);
            r.red = 8'(((p & 32'hf800) >> 11) * 255 / 31);
         end else begin
            r.green = 8'(((p & 32'h03e0) >> 5) * 255 / 31);
            r.red = 8'(((p & 32'h7c00) >> 10) * 255 / 31);
         end
      end else begin
         r.blue = p[7:0];
         r.green = p[15:8];
         r.red = p[23:16];
      end
      r.alpha = 8'd255;
      r.width = img_w[9:0];
      r.height = img_h[9:0];
      expected_results.push_back(r);
   endtask

   task automatic predict_byte(input logic [7:0] b, input logic st);
      int v;
      int unsigned col, k;
      if (st) begin
         stage = bmpd_pkg::ST_HEADER;
         pos = 0;
         rows = 0;
         row_bytes = 0;
         pix_acc = 0;
      end else if (stage != bmpd_pkg::ST_HEADER && stage != bmpd_pkg::ST_PIXELS) begin
         return;
      end
      if (stage == bmpd_pkg::ST_HEADER) begin
         if (pos < 66) hdr[pos] = b;
         if (pos == 0 && (file_len < 54 || file_len > bmpd_pkg::MAX_FILE_BYTES)) begin
            push_verdict(0);
            return;
         end
         if (pos == 53) begin
            v = header_verdict();
            if (v != 2) begin
               push_verdict(v == 1);
               return;
            end
         end else if (pos == 65) begin
            push_verdict(masks_ok());
            return;
         end
         pos++;
         return;
      end
      if (pos < img_off) begin
         pos++;
         return;
      end
      col = row_bytes / bpb;
      k = row_bytes % bpb;
      if (col < img_w) begin
         if (k < 3) pix_acc = pix_acc | (int'(b) << (8 * k));
         if (k == bpb - 1) begin
            push_pixel(col);
            pix_acc = 0;
         end
      end
      row_bytes++;
      if (row_bytes >= stride) begin
         row_bytes = 0;
         rows++;
         if (rows >= img_h) stage = bmpd_pkg::ST_DONE;
      end
      pos++;
   endtask

   task automatic report(input string what, input int unsigned got, input int unsigned want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      checked = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      result_type e;
      if (reset) begin
         file_len = '0;
         max_dec = 21'd1048576;
         stage = bmpd_pkg::ST_IDLE;
         pos = 0;
         rows = 0;
         row_bytes = 0;
         pix_acc = 0;
         expected_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == bmpd_pkg::CSR_FILE_LENGTH) file_len = csr_data;
            else max_dec = csr_data;
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report("result with nothing expected, kind", rsp_kind, 0);
            end else begin
               e = expected_results.pop_front();
               checked++;
               if (rsp_kind != e.kind) report("kind", rsp_kind, e.kind);
               if (rsp_pixel_index != e.index) report("pixel_index", rsp_pixel_index, e.index);
               if (rsp_blue != e.blue) report("blue", rsp_blue, e.blue);
               if (rsp_green != e.green) report("green", rsp_green, e.green);
               if (rsp_red != e.red) report("red", rsp_red, e.red);
               if (rsp_alpha != e.alpha) report("alpha", rsp_alpha, e.alpha);
               if (rsp_image_width != e.width) report("image_width", rsp_image_width, e.width);
               if (rsp_image_height != e.height)
                  report("image_height", rsp_image_height, e.height);
            end
         end
         if (req_valid && !req_stall) predict_byte(req_data_byte, req_start_req);
      end
      pending = expected_results.size();
   end
endmodule

// ===== test/tb.sv =====
// top of the bmp pixel decoder testbench: clock, reset, file stimulus and verdict
// depends on bmpd_pkg, bmp_preview_pixel_decoder and bmpd_checker
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;

   logic        clock, reset;
   logic        req_valid, req_stall, req_start_req;
   logic [7:0]  req_data_byte;
   logic        rsp_valid, rsp_stall;
   logic [1:0]  rsp_kind;
   logic [17:0] rsp_pixel_index;
   logic [7:0]  rsp_blue, rsp_green, rsp_red, rsp_alpha;
   logic [9:0]  rsp_image_width, rsp_image_height;
   logic        csr_valid, csr_ready;
   logic [0:0]  csr_index;
   logic [20:0] csr_data;
   int          fail_count, pending, checked;

   int          cycles;
   int          sent;
   int          files;
   bit          calm;
   bit          hold_wanted, hold_done;
   logic [7:0]  file_bytes[$];
   int unsigned file_size;

   bmp_preview_pixel_decoder dut (.*);

   bmpd_checker u_checker (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // result side back-pressure, with one long hold to fill the block
   initial begin
      rsp_stall = 0;
      hold_done = 0;
      forever begin
         @(posedge clock);
         if (hold_wanted && !hold_done && req_valid) begin
            rsp_stall <= 1;
            repeat (300) @(posedge clock);
            rsp_stall <= 0;
            hold_done = 1;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_stall <= 0;
         end
      end
   end

   task automatic put16(input int unsigned v);
      file_bytes.push_back(v[7:0]);
      file_bytes.push_back(v[15:8]);
   endtask

   task automatic put32(input int unsigned v);
      put16(v[15:0]);
      put16(v[31:16]);
   endtask

   // builds a well formed file; file_size is the length it needs
   task automatic make_file(input int w, input int h, input int bpp, input int comp,
                            input bit m565, input int extra_off, input bit zero_off);
      int unsigned stride, habs, minimum, off;
      file_bytes.delete();
      habs = (h < 0) ? -h : h;
      stride = ((w * bpp + 31) / 32) * 4;
      minimum = (comp == 3) ? 66 : 54;
      off = minimum + extra_off;
      file_size = off + stride * habs;
      file_bytes.push_back(8'h42);
      file_bytes.push_back(8'h4d);
      put32(file_size);
      put32(0);
      put32(zero_off ? 0 : off);
      put32(40);
      put32(w);
      put32(h);
      put16(1);
      put16(bpp);
      put32(comp);
      put32(stride * habs);
      put32($urandom);
      put32($urandom);
      put32(0);
      put32(0);
      if (comp == 3) begin
         put32(m565 ? 32'hf800 : 32'h7c00);
         put32(m565 ? 32'h07e0 : 32'h03e0);
         put32(32'h1f);
      end
      while (file_bytes.size() < file_size) file_bytes.push_back(8'($urandom));
   endtask

   task automatic csr_write(input logic [0:0] idx, input logic [20:0] value);
      @(posedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
   endtask

   task automatic send_byte(input logic [7:0] b, input logic st);
      if (!calm && $urandom_range(0, 6) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1;
      req_data_byte <= b;
      req_start_req <= st;
      do @(posedge clock); while (req_stall);
      sent++;
   endtask

   task automatic wait_quiet();
      req_valid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // streams the current file; a stop before the end leaves it unfinished
   task automatic run_file(input logic [20:0] flen, input logic [20:0] limit, input int stop_at);
      wait_quiet();
      csr_write(bmpd_pkg::CSR_FILE_LENGTH, flen);
      csr_write(bmpd_pkg::CSR_MAX_DECODED, limit);
      @(posedge clock);
      for (int i = 0; i < file_bytes.size() && i < stop_at; i++) send_byte(file_bytes[i], i == 0);
      files++;
   endtask

   initial begin
      int w, h, bpp, comp, pick, spot;
      logic [20:0] flen, limit;
      cycles = 0;
      sent = 0;
      files = 0;
      calm = 0;
      hold_wanted = 0;
      reset = 1;
      req_valid = 0;
      req_data_byte = 0;
      req_start_req = 0;
      csr_valid = 0;
      csr_index = 0;
      csr_data = 0;
      repeat (3) @(posedge clock);
      reset <= 0;

      // bytes before any start are ignored
      repeat (3) send_byte(8'($urandom), 0);
      // length register extremes rejected on byte zero
      make_file(1, 1, 24, 0, 0, 0, 0);
      run_file(0, 21'd1048576, 4);
      run_file(21'd53, 21'd1048576, 2);
      run_file(21'h1fffff, 21'd1048576, 2);
      run_file(21'd1048577, 21'd0, 2);
      // largest image, header only
      make_file(512, -512, 16, 0, 0, 0, 1);
      run_file(21'd1048576, 21'd1048576, 54);
      // decoded size limit of zero
      make_file(1, 1, 32, 0, 0, 0, 0);
      run_file(21'(file_size), 21'd0, 999);
      make_file(2, 1, 16, 3, 0, 0, 1);
      run_file(21'(file_size), 21'd1048576, 999);
      make_file(1, -2, 16, 3, 1, 2, 0);
      run_file(21'(file_size), 21'd8, 999);
      make_file(2, 2, 16, 0, 0, 0, 0);
      run_file(21'(file_size), 21'd1048576, 999);
      make_file(3, -1, 24, 0, 0, 1, 0);
      run_file(21'(file_size + 3), 21'd1048576, 999);
      make_file(1, 1, 24, 0, 0, 0, 0);
      file_bytes[1] = 8'h4e;
      run_file(21'(file_size), 21'd1048576, 999);

      while (sent < 1550) begin
         if (files == 14) hold_wanted = 1;
         if (sent > 1250) calm = 1;
         w = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 6);
         h = $urandom_range(1, 4);
         if ($urandom_range(0, 1)) h = -h;
         pick = $urandom_range(0, 2);
         bpp = (pick == 0) ? 16 : (pick == 1) ? 24 : 32;
         comp = (bpp == 16 && $urandom_range(0, 1)) ? 3 : 0;
         make_file(w, h, bpp, comp, $urandom_range(0, 1), $urandom_range(0, 5),
                   $urandom_range(0, 3) == 0);
         flen = 21'(file_size + $urandom_range(0, 2));
         limit = 21'd1048576;
         spot = 999999;
         pick = $urandom_range(0, 19);
         if (pick < 2)
            file_bytes[$urandom_range(0, (file_size - 1 < 65) ? file_size - 1 : 65)] =
               8'($urandom);
         else if (pick == 2) spot = $urandom_range(1, file_size - 1);
         else if (pick == 3) flen = 21'(file_size - 1);
         else if (pick == 4) limit = 21'(w * (h < 0 ? -h : h) * 4 - 1);
         else if (pick == 5) limit = 21'(w * (h < 0 ? -h : h) * 4);
         if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 0);
         run_file(flen, limit, spot);
      end

      req_valid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("sent %0d request bytes in %0d files, checked %0d results", sent, files, checked);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
